// ----- sv/lsm_pkg.sv -----
// Shared types, constants and codes for the line substring match block.
`timescale 1ns / 1ps

package lsm_pkg;

  // Fixed field widths.
  localparam int CHAR_W    = 8;
  localparam int POS_W     = 8;
  localparam int LINE_W    = 32;
  localparam int CFG_W     = 64;
  localparam int PLEN_W    = 5;
  localparam int CFG_IDX_W = 2;

  // Default sizes handed to the top level parameters.
  localparam int PATTERN_MAX_DEFAULT   = 16;
  localparam int SEGMENT_CHARS_DEFAULT = 255;

  // Byte that closes a line.
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd2;

  // Queue between the front and back ends.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Operation codes given to a classified word.
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_CHAR    = 2'd0;
  localparam logic [OP_W-1:0] OP_NEWLINE = 2'd1;
  localparam logic [OP_W-1:0] OP_DROP    = 2'd2;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_input;
  } lsm_in_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_number;
    logic [POS_W-1:0]  match_start;
    logic [POS_W-1:0]  match_end;
  } lsm_out_t;

  // A classified word as it waits in the queue.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
  } lsm_op_t;

endpackage

// ----- sv/lsm_front.sv -----
// Front end: accepts text words and classifies them for the back end.
`timescale 1ns / 1ps

module lsm_front (
  input  logic            text_valid,
  output logic            text_stall,
  input  lsm_pkg::lsm_in_t text_word,
  output logic            push,
  output lsm_pkg::lsm_op_t push_word,
  input  logic            queue_full
);
  import lsm_pkg::*;

  // A word is taken whenever the queue has room.
  assign text_stall = queue_full;
  assign push       = text_valid && !queue_full;

  // End of input takes precedence over the byte, which it ignores.
  always_comb begin
    push_word.char_code = text_word.char_code;
    if (text_word.end_of_input) begin
      push_word.op = OP_DROP;
    end else if (text_word.char_code == NEWLINE_CODE) begin
      push_word.op = OP_NEWLINE;
    end else begin
      push_word.op = OP_CHAR;
    end
  end

endmodule

// ----- sv/lsm_queue.sv -----
// Short queue of classified words between the front and back ends.
`timescale 1ns / 1ps

module lsm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lsm_pkg::lsm_op_t push_word,
  output logic             full,
  output logic             pop_valid,
  output lsm_pkg::lsm_op_t pop_word,
  input  logic             pop
);
  import lsm_pkg::*;

  lsm_op_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  logic               do_push;
  logic               do_pop;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_word  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_word;
    end
  end

endmodule

// ----- sv/lsm_back.sv -----
// Back end: keeps the line window, compares it with the pattern and forms results.
`timescale 1ns / 1ps

module lsm_back #(
  parameter int PATTERN_MAX   = lsm_pkg::PATTERN_MAX_DEFAULT,
  parameter int SEGMENT_CHARS = lsm_pkg::SEGMENT_CHARS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    op_valid,
  input  lsm_pkg::lsm_op_t                        op_word,
  output logic                                    op_take,
  input  logic [PATTERN_MAX*lsm_pkg::CHAR_W-1:0]  pattern,
  input  logic [lsm_pkg::PLEN_W-1:0]              pattern_length,
  output logic                                    hit_valid,
  input  logic                                    hit_stall,
  output lsm_pkg::lsm_out_t                       hit_word
);
  import lsm_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic [CHAR_W-1:0] window     [PATTERN_MAX];
  logic [CHAR_W-1:0] window_new [PATTERN_MAX];
  logic [CHAR_W-1:0] aligned    [PATTERN_MAX];
  logic [POS_W-1:0]  line_position;
  logic [POS_W-1:0]  pos_new;
  logic [LINE_W-1:0] current_line;
  logic              found_flag;
  logic [POS_W-1:0]  found_start;
  logic [PLEN_W-1:0] len_clamped;
  logic [LEN_W-1:0]  len;
  logic              window_hit;
  logic              found_now;
  logic [POS_W-1:0]  start_now;
  logic              seg_full;
  logic              finish;
  logic              emit;

  // Pattern length in force, clamped to the window depth.
  assign len_clamped = (pattern_length > PLEN_W'(PATTERN_MAX)) ?
                       PLEN_W'(PATTERN_MAX) : pattern_length;
  assign len         = LEN_W'(len_clamped);

  // Pattern byte that lines up with each window entry (entry 0 is the newest byte).
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      aligned[k] = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (int'(len) == j + k + 1) begin
          aligned[k] = pattern[j*CHAR_W +: CHAR_W];
        end
      end
    end
  end

  // Window as it stands once the incoming byte is shifted in.
  always_comb begin
    window_new[0] = op_word.char_code;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      window_new[k] = window[k-1];
    end
  end

  assign pos_new = line_position + 1'b1;

  // Parallel compare over the last len bytes of the line.
  always_comb begin
    window_hit = (len != '0) && (pos_new >= POS_W'(len));
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if ((k < int'(len)) && (window_new[k] != aligned[k])) begin
        window_hit = 1'b0;
      end
    end
  end

  assign found_now = found_flag || window_hit;
  assign start_now = found_flag ? found_start : (pos_new - POS_W'(len));
  assign seg_full  = (pos_new >= POS_W'(SEGMENT_CHARS));

  // A word is executed when the result register is free or being emptied.
  assign op_take = op_valid && (!hit_valid || !hit_stall);

  // Decide whether the word closes a line and whether that line gives a result.
  always_comb begin
    finish = 1'b0;
    emit   = 1'b0;
    case (op_word.op)
      OP_NEWLINE: begin
        finish = 1'b1;
        emit   = found_flag;
      end
      OP_CHAR: begin
        finish = seg_full;
        emit   = seg_full && found_now;
      end
      default: begin
        finish = 1'b0;
        emit   = 1'b0;
      end
    endcase
  end

  // Line control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_position <= '0;
      current_line  <= LINE_W'(1);
      found_flag    <= 1'b0;
    end else if (op_take) begin
      if (finish) begin
        line_position <= '0;
        current_line  <= current_line + 1'b1;
        found_flag    <= 1'b0;
      end else if (op_word.op == OP_DROP) begin
        line_position <= '0;
        found_flag    <= 1'b0;
      end else if (op_word.op == OP_CHAR) begin
        line_position <= pos_new;
        found_flag    <= found_now;
      end
    end
  end

  // Window bytes and match start carry no reset: they are only read once
  // enough bytes of the current line have arrived.
  always_ff @(posedge clk) begin
    if (op_take && (op_word.op == OP_CHAR)) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        window[k] <= window_new[k];
      end
      found_start <= start_now;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (op_take && emit) begin
      hit_valid <= 1'b1;
    end else if (!hit_stall) begin
      hit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_take && emit) begin
      hit_word.line_number <= current_line;
      if (op_word.op == OP_NEWLINE) begin
        hit_word.match_start <= found_start;
        hit_word.match_end   <= found_start + POS_W'(len);
      end else begin
        hit_word.match_start <= start_now;
        hit_word.match_end   <= start_now + POS_W'(len);
      end
    end
  end

endmodule

// ----- sv/line_substring_match_core.sv -----
// Top level of the line substring match block: configuration and wiring.
`timescale 1ns / 1ps

// Finds the first occurrence of a pattern of up to PATTERN_MAX bytes in each
// line of a byte stream and reports the line number and the start and end
// positions of the match when a matching line ends. Lines close at a
// newline or after SEGMENT_CHARS bytes; an end-of-input word drops the
// partial line. One text word is taken per cycle while the queue has room: the
// front end classifies it into a four-word queue, and the back end executes one
// queued word per cycle unless a result is held by a stalled consumer, with a
// parallel compare of the whole window. Each word that the front end takes is
// registered in the queue before the back end executes it, and the word that
// closes a matching line loads the output register as it is executed.
// While a result is held by a stalled consumer the back end waits, and the
// queue keeps taking text until it is full. The pattern registers may only be
// written while the block is idle.
module line_substring_match_core #(
  parameter int PATTERN_MAX   = lsm_pkg::PATTERN_MAX_DEFAULT,
  parameter int SEGMENT_CHARS = lsm_pkg::SEGMENT_CHARS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            text_valid,
  output logic                            text_stall,
  input  lsm_pkg::lsm_in_t                text_word,
  output logic                            hit_valid,
  input  logic                            hit_stall,
  output lsm_pkg::lsm_out_t               hit_word,
  input  logic                            cfg_write,
  input  logic [lsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsm_pkg::CFG_W-1:0]       cfg_data
);
  import lsm_pkg::*;

  logic [CFG_W-1:0]              pattern_low_bytes;
  logic [CFG_W-1:0]              pattern_high_bytes;
  logic [PLEN_W-1:0]             pattern_length;
  logic [2*CFG_W-1:0]            pattern_all;
  logic [PATTERN_MAX*CHAR_W-1:0] pattern;
  logic                          push;
  lsm_op_t                       push_word;
  logic                          queue_full;
  logic                          pop_valid;
  lsm_op_t                       pop_word;
  logic                          pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
      pattern_length     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PATTERN_LOW:  pattern_low_bytes  <= cfg_data;
        CFG_PATTERN_HIGH: pattern_high_bytes <= cfg_data;
        CFG_PATTERN_LEN:  pattern_length     <= cfg_data[PLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Only the bytes the window can use are handed on.
  assign pattern_all = {pattern_high_bytes, pattern_low_bytes};
  assign pattern     = pattern_all[PATTERN_MAX*CHAR_W-1:0];

  lsm_front u_front (
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_word  (text_word),
    .push       (push),
    .push_word  (push_word),
    .queue_full (queue_full)
  );

  lsm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (queue_full),
    .pop_valid (pop_valid),
    .pop_word  (pop_word),
    .pop       (pop)
  );

  lsm_back #(
    .PATTERN_MAX   (PATTERN_MAX),
    .SEGMENT_CHARS (SEGMENT_CHARS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .op_valid       (pop_valid),
    .op_word        (pop_word),
    .op_take        (pop),
    .pattern        (pattern),
    .pattern_length (pattern_length),
    .hit_valid      (hit_valid),
    .hit_stall      (hit_stall),
    .hit_word       (hit_word)
  );

endmodule

// ----- sim/lsm_match_checker.sv -----
// Checker that predicts the match reports of the line substring match block and compares them.
`timescale 1ns / 1ps

module lsm_match_checker #(
  parameter int PATTERN_MAX   = lsm_pkg::PATTERN_MAX_DEFAULT,
  parameter int SEGMENT_CHARS = lsm_pkg::SEGMENT_CHARS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          text_valid,
  input  logic                          text_stall,
  input  lsm_pkg::lsm_in_t              text_word,
  input  logic                          hit_valid,
  input  logic                          hit_stall,
  input  lsm_pkg::lsm_out_t             hit_word,
  input  logic                          cfg_write,
  input  logic [lsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          run_done,
  output int                            pending,
  output int                            errors,
  output int                            hits_seen
);
  import lsm_pkg::*;

  localparam int WINDOW = 16;
  localparam int SHOWN  = 10;

  // Our own copy of the pattern registers.
  logic [CFG_W-1:0]  pat_lo;
  logic [CFG_W-1:0]  pat_hi;
  logic [PLEN_W-1:0] pat_len;

  // Per-line search state.
  logic [CHAR_W-1:0] tail [WINDOW];
  logic [POS_W-1:0]  line_pos;
  logic [LINE_W-1:0] line_no;
  logic              seen;
  logic [POS_W-1:0]  seen_start;

  lsm_out_t hits_due [$];
  lsm_out_t due;
  int       err_cnt;
  int       hit_cnt;
  logic     end_done;

  // Pattern length actually compared, clamped to the window.
  function automatic int used_len();
    int n;
    n = int'(pat_len);
    if (n > PATTERN_MAX) n = PATTERN_MAX;
    if (n > WINDOW) n = WINDOW;
    return n;
  endfunction

  function automatic logic [CHAR_W-1:0] pat_byte(int k);
    logic [CHAR_W-1:0] b;
    if (k < 8) begin
      b = pat_lo[k*8 +: 8];
    end else begin
      b = pat_hi[(k-8)*8 +: 8];
    end
    return b;
  endfunction

  // The newest n bytes of the line equal the pattern, newest byte last.
  function automatic logic tail_matches(int n);
    int j;
    if (n == 0 || line_pos < n) return 1'b0;
    for (j = 0; j < n; j++) begin
      if (tail[j] != pat_byte(n - 1 - j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_line();
    int j;
    for (j = 0; j < WINDOW; j++) tail[j] = '0;
    line_pos   = '0;
    seen       = 1'b0;
    seen_start = '0;
  endtask

  // A line ends: queue a report if it held the pattern, then move on.
  task automatic close_line();
    lsm_out_t r;
    logic [POS_W-1:0] len8;
    if (seen) begin
      len8          = POS_W'(used_len());
      r.line_number = line_no;
      r.match_start = seen_start;
      r.match_end   = seen_start + len8;
      hits_due.push_back(r);
    end
    line_no = line_no + 1'b1;
    clear_line();
  endtask

  task automatic take_word(lsm_in_t w);
    int n;
    int j;
    if (w.end_of_input) begin
      clear_line();
    end else if (w.char_code == NEWLINE_CODE) begin
      close_line();
    end else begin
      for (j = WINDOW - 1; j > 0; j--) tail[j] = tail[j-1];
      tail[0]  = w.char_code;
      line_pos = line_pos + 1'b1;
      n = used_len();
      if (!seen && tail_matches(n)) begin
        seen       = 1'b1;
        seen_start = line_pos - POS_W'(n);
      end
      if (line_pos >= SEGMENT_CHARS) close_line();
    end
  endtask

  task automatic field_error(string name, logic [LINE_W-1:0] want, logic [LINE_W-1:0] got);
    err_cnt++;
    if (err_cnt <= SHOWN) begin
      $display("%0t: %s mismatch on line report: expected %0d, got %0d", $realtime, name,
               want, got);
    end
  endtask

  // Follow the configuration port, predict from accepted words, check each report.
  always @(posedge clk) begin
    if (rst) begin
      pat_lo   = '0;
      pat_hi   = '0;
      pat_len  = '0;
      line_no  = 1;
      clear_line();
      hits_due.delete();
      err_cnt  = 0;
      hit_cnt  = 0;
      end_done = 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PATTERN_LOW: begin
            pat_lo = cfg_data;
          end
          CFG_PATTERN_HIGH: begin
            pat_hi = cfg_data;
          end
          CFG_PATTERN_LEN: begin
            pat_len = cfg_data[PLEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (text_valid && !text_stall) take_word(text_word);
      if (hit_valid && !hit_stall) begin
        if (hits_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= SHOWN) begin
            $display("%0t: report with none due: line %0d start %0d end %0d", $realtime,
                     hit_word.line_number, hit_word.match_start, hit_word.match_end);
          end
        end else begin
          due = hits_due.pop_front();
          hit_cnt++;
          if (hit_word.line_number !== due.line_number)
            field_error("line_number", due.line_number, hit_word.line_number);
          if (hit_word.match_start !== due.match_start)
            field_error("match_start", due.match_start, hit_word.match_start);
          if (hit_word.match_end !== due.match_end)
            field_error("match_end", due.match_end, hit_word.match_end);
        end
      end
      // Anything still due at the end never arrived.
      if (run_done && !end_done) begin
        end_done = 1'b1;
        if (hits_due.size() != 0) begin
          $display("%0d match reports never arrived", hits_due.size());
          err_cnt += hits_due.size();
        end
      end
    end
    pending   <= hits_due.size();
    errors    <= err_cnt;
    hits_seen <= hit_cnt;
  end

endmodule

// ----- sim/tb.sv -----
// Top of the line substring match testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import lsm_pkg::*;

  localparam int ITEMS         = 1850;
  localparam int PHASES        = 9;
  localparam int MIN_HITS      = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DIRECTED_LEN  = 24;

  typedef enum {END_NEWLINE, END_DROP, END_OPEN} line_end_e;

  // Directed words: bit 8 is end of input, the rest the byte.
  localparam logic [8:0] W_A    = 9'h061;
  localparam logic [8:0] W_X    = 9'h078;
  localparam logic [8:0] W_ZERO = 9'h000;
  localparam logic [8:0] W_ONES = 9'h0FF;
  localparam logic [8:0] W_NL   = {1'b0, NEWLINE_CODE};
  localparam logic [8:0] W_DROP = {1'b1, NEWLINE_CODE};
  localparam logic [8:0] DIRECTED [DIRECTED_LEN] = '{
    W_A, W_ZERO, W_ONES, W_NL,
    W_X, W_A, W_ZERO, W_ONES, W_A, W_ZERO, W_ONES, W_NL,
    W_NL,
    W_A, W_ZERO, W_DROP,
    W_ZERO, W_ONES, W_NL,
    W_A, W_A, W_ZERO, W_ONES, W_NL
  };

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 text_valid = 1'b0;
  logic                 text_stall;
  lsm_in_t              text_word  = '0;
  logic                 hit_valid;
  logic                 hit_stall  = 1'b0;
  lsm_out_t             hit_word;
  logic                 cfg_write  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_PATTERN_LOW;
  logic [CFG_W-1:0]     cfg_data   = '0;
  logic                 run_done   = 1'b0;
  logic                 hold_req   = 1'b0;
  logic                 hold_on    = 1'b0;
  int                   recv_idle_pct = 0;
  int                   send_idle_pct = 0;
  int                   pending;
  int                   errors;
  int                   hits_seen;
  int                   words_sent = 0;
  int                   settings_used = 0;

  // Stimulus copy of the pattern, used to build lines that hit it.
  logic [CFG_W-1:0] cur_lo;
  logic [CFG_W-1:0] cur_hi;
  int               cur_n;

  line_substring_match_core uut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_word  (text_word),
    .hit_valid  (hit_valid),
    .hit_stall  (hit_stall),
    .hit_word   (hit_word),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  lsm_match_checker chk (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_word  (text_word),
    .hit_valid  (hit_valid),
    .hit_stall  (hit_stall),
    .hit_word   (hit_word),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .run_done   (run_done),
    .pending    (pending),
    .errors     (errors),
    .hits_seen  (hits_seen)
  );

  always #1 clk = ~clk;

  // Output side: random stalls, or a solid stall while the long hold-off runs.
  always @(posedge clk) begin
    if (hold_on) begin
      hit_stall <= 1'b1;
    end else begin
      hit_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Long hold-off on the output, so the block backs up and stalls its input.
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Hard limit on the run time.
  initial begin
    #1_000_000;
    $display("Run stopped by the time limit with %0d reports outstanding", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one word, idling first at random, and wait until it is taken.
  task automatic push_word(input logic [CHAR_W-1:0] c, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      text_valid <= 1'b0;
      @(posedge clk);
    end
    text_valid <= 1'b1;
    text_word  <= '{char_code: c, end_of_input: eoi};
    @(posedge clk);
    while (text_stall) @(posedge clk);
    words_sent++;
  endtask

  // Stop sending and wait until every report is in and the queue has emptied.
  task automatic drain();
    text_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_pattern(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                              input logic [PLEN_W-1:0] len);
    cfg_write <= 1'b1;
    cfg_index <= CFG_PATTERN_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_PATTERN_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= CFG_PATTERN_LEN;
    cfg_data  <= CFG_W'(len);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
    cur_n  = (len > 16) ? 16 : int'(len);
    settings_used++;
  endtask

  function automatic logic [CHAR_W-1:0] pattern_byte(int k);
    logic [CHAR_W-1:0] b;
    if (k < 8) begin
      b = cur_lo[k*8 +: 8];
    end else begin
      b = cur_hi[(k-8)*8 +: 8];
    end
    return b;
  endfunction

  // Mostly pattern bytes, so partial matches are common.
  function automatic logic [CHAR_W-1:0] text_byte();
    logic [CHAR_W-1:0] b;
    if (cur_n > 0 && $urandom_range(9) < 7) begin
      b = pattern_byte($urandom_range(cur_n - 1));
    end else begin
      b = CHAR_W'($urandom_range(255));
    end
    return b;
  endfunction

  // Mostly short lines, now and then a full segment or longer.
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 2) return 255;
    if (r < 4) return $urandom_range(300, 200);
    return $urandom_range(30, 0);
  endfunction

  task automatic send_line(input int len, input bit plant, input line_end_e ending);
    logic [CHAR_W-1:0] body [$];
    int at;
    int j;
    for (j = 0; j < len; j++) body.push_back(text_byte());
    if (plant && cur_n > 0 && len >= cur_n) begin
      at = $urandom_range(len - cur_n);
      for (j = 0; j < cur_n; j++) body[at + j] = pattern_byte(j);
    end
    foreach (body[j]) push_word(body[j], 1'b0);
    case (ending)
      END_NEWLINE: begin
        push_word(NEWLINE_CODE, 1'b0);
      end
      END_DROP: begin
        push_word(CHAR_W'($urandom_range(255)), 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  function automatic line_end_e pick_ending();
    int r;
    r = $urandom_range(99);
    if (r < 85) return END_NEWLINE;
    if (r < 93) return END_DROP;
    return END_OPEN;
  endfunction

  // Main stimulus: directed words, then random phases over several patterns.
  initial begin
    int ph;
    int phase_start;
    int budget;
    logic [PLEN_W-1:0] len;
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 6;
    recv_idle_pct <= 69;

    // Pattern "a", zero byte, 0xFF: start of line, later hit, empty line,
    // dropped partial line, and the overlapping restart after a near miss.
    load_pattern(64'h0000_0000_00FF_0061, '1, 5'd3);
    foreach (DIRECTED[j]) push_word(DIRECTED[j][CHAR_W-1:0], DIRECTED[j][8]);

    budget = ITEMS / PHASES;
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph / 3)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct <= 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct <= 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase

      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case (ph)
        0: len = 5'd1;
        1: len = 5'd16;
        2: len = 5'd0;
        3: begin
          lo  = '1;
          hi  = '1;
          len = 5'd31;
        end
        4: len = PLEN_W'($urandom_range(6, 2));
        5: begin
          lo  = '0;
          hi  = '0;
          len = 5'd4;
        end
        7: len = PLEN_W'($urandom_range(30, 17));
        8: len = PLEN_W'($urandom_range(8, 1));
        default: len = PLEN_W'($urandom_range(16, 1));
      endcase
      load_pattern(lo, hi, len);

      if (ph == 6) hold_req <= 1'b1;

      phase_start = words_sent;
      while (words_sent - phase_start < budget ||
             (ph == PHASES - 1 && hits_seen + pending < MIN_HITS)) begin
        send_line(pick_length(), $urandom_range(9) < 7, pick_ending());
      end

      // Leave a matched line open so the next pattern settings apply to its end.
      if (ph % 2 == 1) send_line($urandom_range(20, 16), 1'b1, END_OPEN);
    end

    drain();
    run_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Sent %0d text words under %0d pattern settings; %0d match reports checked.",
             words_sent, settings_used, hits_seen);
    $display("Included empty, short, full and clamped patterns, zero and 0xFF bytes, "
             , "full segments, dropped lines and a long output hold-off.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
